[design/adm_pkg.sv]
// Shared types, constants and channel scaling functions for the ADC decimate and average block.
`timescale 1ns / 1ps

package adm_pkg;

    localparam int MAX_CH           = 4;
    localparam int SAMPLE_W         = 12;
    localparam int SUM_W            = 16;
    localparam int FAULT_W          = 2;
    localparam int VALUE_W          = 9;
    localparam int OFFSET_W         = 8;
    localparam int SCALED_W         = 12;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int DECIMATION_DEF   = 16;
    localparam int HISTORY_LEN_DEF  = 10;

    localparam int LIMIT_HIGH       = 4000;
    localparam int LIMIT_LOW        = 2000;
    localparam int AVG_DIVISOR      = 100;

    // Pipeline depth of one constant divider, and of a whole lane from the accept edge.
    localparam int DIV_LAT          = 3;
    localparam int LANE_LAT         = 5 + 3 * DIV_LAT;
    localparam int FIFO_DEPTH       = 16;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_ABOVE = 2'd1,
        FAULT_BELOW = 2'd2
    } fault_t;

    typedef struct packed {
        logic acc;
        logic decim;
    } lane_ctl_t;

    typedef struct packed {
        logic [MAX_CH-1:0][FAULT_W-1:0] fault;
        logic [MAX_CH-1:0][VALUE_W-1:0] value;
        logic                           updated;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic fault_t fault_code(logic [SAMPLE_W-1:0] s);
        fault_t f;
        priority if (s > SAMPLE_W'(LIMIT_HIGH))
            f = FAULT_ABOVE;
        else if (s <= SAMPLE_W'(LIMIT_LOW))
            f = FAULT_BELOW;
        else
            f = FAULT_NONE;
        return f;
    endfunction

    function automatic int scale_mul(int ch);
        return (ch == 0) ? 5990 : 33000;
    endfunction

    function automatic int full_scale(int ch);
        return (ch == 0) ? 65535 : 65520;
    endfunction

    function automatic int post_mul(int ch);
        return (ch == 0) ? 33 : 1;
    endfunction

    function automatic int post_div(int ch);
        int d;
        if (ch == 0)
            d = 100;
        else if (ch == 1)
            d = 331;
        else
            d = 11;
        return d;
    endfunction

    function automatic int value_max(int ch);
        return (ch == 1) ? 15 : 511;
    endfunction

endpackage

[design/adm_const_div.sv]
// Pipelined divider by a constant: reciprocal multiply followed by a single correction step.
`timescale 1ns / 1ps

module adm_const_div
    import adm_pkg::*;
#(
    parameter int X_W     = 32,
    parameter int Q_W     = 16,
    parameter int DIVISOR = 100
)
(
    input  logic           clk,
    input  logic [X_W-1:0] x,
    output logic [Q_W-1:0] q
);

    localparam longint unsigned M_L = (64'd1 << X_W) / DIVISOR;
    localparam int              M_W = $clog2(M_L + 1);
    localparam int              P_W = X_W + M_W;
    localparam logic [M_W-1:0]  M_C = M_W'(M_L);
    localparam logic [X_W-1:0]  D_C = X_W'(DIVISOR);

    logic [P_W-1:0] prod_reg;
    logic [X_W-1:0] xa_reg;
    logic [X_W-1:0] xb_reg;
    logic [X_W-1:0] qb_reg;
    logic [X_W-1:0] qd_reg;
    logic [Q_W-1:0] q_reg;

    logic [X_W-1:0] q_est;
    logic [X_W-1:0] rem;

    // The estimate never exceeds the true quotient and is short by at most one.
    assign q_est = X_W'(prod_reg >> X_W);
    assign rem   = xb_reg - qd_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= P_W'(x) * P_W'(M_C);
        xa_reg   <= x;
        qb_reg   <= q_est;
        qd_reg   <= q_est * D_C;
        xb_reg   <= xa_reg;
        q_reg    <= Q_W'(qb_reg + X_W'(rem >= D_C));
    end

    assign q = q_reg;

endmodule

[design/adm_lane.sv]
// One channel lane: fault code, accumulator, scaling chain, history ring and held average.
`timescale 1ns / 1ps

module adm_lane
    import adm_pkg::*;
#(
    parameter int CH          = 0,
    parameter int HISTORY_LEN = HISTORY_LEN_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lane_ctl_t           ctl,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [OFFSET_W-1:0] offset,
    output logic [FAULT_W-1:0]  fault,
    output logic [VALUE_W-1:0]  value
);

    localparam int PROD_W   = 32;
    localparam int T_W      = 16;
    localparam int M2_W     = 18;
    localparam int RSUM_W   = SCALED_W + $clog2(HISTORY_LEN);
    localparam int SUMV_W   = RSUM_W + 1;
    localparam int POS_W    = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int RING_IDX = 2 + 2 * DIV_LAT;
    localparam int HELD_IDX = 3 + 3 * DIV_LAT;

    localparam logic [PROD_W-1:0] SCALE_C = PROD_W'(scale_mul(CH));
    localparam logic [M2_W-1:0]   POST_C  = M2_W'(post_mul(CH));
    localparam logic [SUMV_W-1:0] VMAX_C  = SUMV_W'(value_max(CH));
    localparam logic [POS_W-1:0]  LAST_C  = POS_W'(HISTORY_LEN - 1);

    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    s1_sum_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [T_W-1:0]      t_q;
    logic [M2_W-1:0]     m_reg;
    logic [SCALED_W-1:0] scaled_q;
    logic [SCALED_W-1:0] ring_reg [HISTORY_LEN];
    logic [POS_W-1:0]    pos_reg;
    logic [RSUM_W-1:0]   rsum_reg;
    logic [RSUM_W-1:0]   rsum_next;
    logic [RSUM_W-1:0]   avg_q;
    logic [SUMV_W-1:0]   total;
    logic [VALUE_W-1:0]  held_reg;
    logic [VALUE_W-1:0]  held_next;
    fault_t              fault_pipe [LANE_LAT];
    logic [HELD_IDX:0]   upd_pipe;

    assign sum_next = sum_reg + SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            upd_pipe <= '0;
        end
        else
        begin
            if (ctl.acc)
                sum_reg <= ctl.decim ? '0 : sum_next;
            upd_pipe <= {upd_pipe[HELD_IDX-1:0], ctl.acc & ctl.decim};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sum_reg    <= sum_next;
        prod_reg      <= PROD_W'(s1_sum_reg) * SCALE_C;
        m_reg         <= M2_W'(t_q) * POST_C;
        fault_pipe[0] <= fault_code(sample);
        for (int i = 1; i < LANE_LAT; i++)
            fault_pipe[i] <= fault_pipe[i-1];
    end

    adm_const_div #(
        .X_W     (PROD_W),
        .Q_W     (T_W),
        .DIVISOR (full_scale(CH))
    ) u_div_scale (
        .clk (clk),
        .x   (prod_reg),
        .q   (t_q)
    );

    adm_const_div #(
        .X_W     (M2_W),
        .Q_W     (SCALED_W),
        .DIVISOR (post_div(CH))
    ) u_div_post (
        .clk (clk),
        .x   (m_reg),
        .q   (scaled_q)
    );

    // A running sum of the ring replaces the oldest entry instead of adding all entries.
    assign rsum_next = rsum_reg - RSUM_W'(ring_reg[pos_reg]) + RSUM_W'(scaled_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_LEN; i++)
                ring_reg[i] <= '0;
            pos_reg  <= '0;
            rsum_reg <= '0;
        end
        else if (upd_pipe[RING_IDX])
        begin
            ring_reg[pos_reg] <= scaled_q;
            rsum_reg          <= rsum_next;
            pos_reg           <= (pos_reg == LAST_C) ? '0 : pos_reg + POS_W'(1);
        end
    end

    adm_const_div #(
        .X_W     (RSUM_W),
        .Q_W     (RSUM_W),
        .DIVISOR (AVG_DIVISOR)
    ) u_div_avg (
        .clk (clk),
        .x   (rsum_reg),
        .q   (avg_q)
    );

    assign total     = SUMV_W'(avg_q) + ((CH == 0) ? SUMV_W'(offset) : SUMV_W'(0));
    assign held_next = (total > VMAX_C) ? VALUE_W'(VMAX_C) : VALUE_W'(total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (upd_pipe[HELD_IDX])
            held_reg <= held_next;
    end

    assign fault = fault_pipe[LANE_LAT-1];
    assign value = held_reg;

endmodule

[design/adm_out_fifo.sv]
// Result queue between the lane pipeline and the output channel.
`timescale 1ns / 1ps

module adm_out_fifo
    import adm_pkg::*;
#(
    parameter int W     = RESULT_W,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_C = PTR_W'(DEPTH - 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign pop = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

endmodule

[design/adc_decimate_average_fault.sv]
// Top level of the four-channel ADC fault, decimate and moving-average block.
`timescale 1ns / 1ps

// One transaction per clock is accepted and one result per clock is delivered in steady state
// while out_ready stays high. Each channel lane is a 14-stage pipeline (accumulator, scaling
// multiply, post multiply, three constant dividers of three stages each, the history ring
// update and the held-value register), followed by a 16-entry result queue. in_ready drops
// only when 16 accepted transactions have results not yet taken, so a stalled output side is
// absorbed for 16 transactions before the input side is held. Fault codes reflect the sample
// of the same transaction; value fields show the averages held since the last refresh, and
// values_updated marks the transaction that refreshed them. voltage_offset is written through
// cfg_we and cfg_wdata and should change only while the block is idle.

module adc_decimate_average_fault
    import adm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int DECIMATION   = DECIMATION_DEF,
    parameter int HISTORY_LEN  = HISTORY_LEN_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample_0,
    input  logic [SAMPLE_W-1:0] sample_1,
    input  logic [SAMPLE_W-1:0] sample_2,
    input  logic [SAMPLE_W-1:0] sample_3,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FAULT_W-1:0]  fault_0,
    output logic [FAULT_W-1:0]  fault_1,
    output logic [FAULT_W-1:0]  fault_2,
    output logic [FAULT_W-1:0]  fault_3,
    output logic [VALUE_W-1:0]  value_0,
    output logic [3:0]          value_1,
    output logic [VALUE_W-1:0]  value_2,
    output logic [VALUE_W-1:0]  value_3,
    output logic                values_updated,
    input  logic                cfg_we,
    input  logic [OFFSET_W-1:0] cfg_wdata
);

    localparam int TICK_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam logic [TICK_W-1:0] TICK_LAST_C = TICK_W'(DECIMATION - 1);

    logic [OFFSET_W-1:0]              voltage_offset_reg;
    logic [TICK_W-1:0]                tick_reg;
    logic [CNT_W-1:0]                 credit_reg;
    logic [LANE_LAT-1:0]              vld_pipe;
    logic [LANE_LAT-1:0]              upd_pipe;
    logic                             in_acc;
    logic                             out_acc;
    logic                             decim;
    lane_ctl_t                        ctl;
    logic [MAX_CH-1:0][SAMPLE_W-1:0]  samples;
    logic [MAX_CH-1:0][FAULT_W-1:0]   lane_fault;
    logic [MAX_CH-1:0][VALUE_W-1:0]   lane_value;
    result_t                          push_res;
    result_t                          out_res;

    assign in_ready = (credit_reg < CNT_W'(FIFO_DEPTH));
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign decim    = (tick_reg == TICK_LAST_C);

    assign ctl.acc   = in_acc;
    assign ctl.decim = decim;

    assign samples[0] = sample_0;
    assign samples[1] = sample_1;
    assign samples[2] = sample_2;
    assign samples[3] = sample_3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_offset_reg <= '0;
            tick_reg           <= '0;
            credit_reg         <= '0;
            vld_pipe           <= '0;
            upd_pipe           <= '0;
        end
        else
        begin
            if (cfg_we)
                voltage_offset_reg <= cfg_wdata;
            if (in_acc)
                tick_reg <= decim ? '0 : tick_reg + TICK_W'(1);
            // Credits cover transactions in the lanes plus results waiting in the queue.
            credit_reg <= credit_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
            vld_pipe   <= {vld_pipe[LANE_LAT-2:0], in_acc};
            upd_pipe   <= {upd_pipe[LANE_LAT-2:0], in_acc & decim};
        end
    end

    for (genvar c = 0; c < MAX_CH; c++)
    begin : g_ch
        if (c < NUM_CHANNELS)
        begin : g_on
            adm_lane #(
                .CH          (c),
                .HISTORY_LEN (HISTORY_LEN)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .sample (samples[c]),
                .offset (voltage_offset_reg),
                .fault  (lane_fault[c]),
                .value  (lane_value[c])
            );
        end
        else
        begin : g_off
            assign lane_fault[c] = '0;
            assign lane_value[c] = '0;
        end
    end

    assign push_res.fault   = lane_fault;
    assign push_res.value   = lane_value;
    assign push_res.updated = upd_pipe[LANE_LAT-1];

    adm_out_fifo #(
        .W     (RESULT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (vld_pipe[LANE_LAT-1]),
        .push_data (push_res),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (out_res)
    );

    assign fault_0        = out_res.fault[0];
    assign fault_1        = out_res.fault[1];
    assign fault_2        = out_res.fault[2];
    assign fault_3        = out_res.fault[3];
    assign value_0        = out_res.value[0];
    assign value_1        = out_res.value[1][3:0];
    assign value_2        = out_res.value[2];
    assign value_3        = out_res.value[3];
    assign values_updated = out_res.updated;

endmodule

[design/adm_checker.sv]
// Port-level assertions for the ADC decimate and average block, bound to the top level.
`timescale 1ns / 1ps

module adm_checker
    import adm_pkg::*;
#(
    parameter int DECIMATION = DECIMATION_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [SAMPLE_W-1:0] sample_0,
    input logic [SAMPLE_W-1:0] sample_1,
    input logic [SAMPLE_W-1:0] sample_2,
    input logic [SAMPLE_W-1:0] sample_3,
    input logic                out_valid,
    input logic                out_ready,
    input logic [FAULT_W-1:0]  fault_0,
    input logic [FAULT_W-1:0]  fault_1,
    input logic [FAULT_W-1:0]  fault_2,
    input logic [FAULT_W-1:0]  fault_3,
    input logic [VALUE_W-1:0]  value_0,
    input logic [3:0]          value_1,
    input logic [VALUE_W-1:0]  value_2,
    input logic [VALUE_W-1:0]  value_3,
    input logic                values_updated
);

    localparam logic [4:0] GAP_LAST_C = 5'(DECIMATION - 1);

    logic               in_acc;
    logic               out_acc;
    logic [7:0]         pend_reg;
    logic [4:0]         gap_reg;
    logic [VALUE_W-1:0] last0_reg;
    logic [3:0]         last1_reg;
    logic [VALUE_W-1:0] last2_reg;
    logic [VALUE_W-1:0] last3_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            gap_reg   <= '0;
            last0_reg <= '0;
            last1_reg <= '0;
            last2_reg <= '0;
            last3_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 8'(in_acc) - 8'(out_acc);
            if (out_acc)
            begin
                gap_reg   <= values_updated ? '0 : gap_reg + 5'd1;
                last0_reg <= value_0;
                last1_reg <= value_1;
                last2_reg <= value_2;
                last3_reg <= value_3;
            end
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable({sample_0, sample_1, sample_2, sample_3}))
        else $error("input transaction changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({fault_0, fault_1, fault_2, fault_3,
            value_0, value_1, value_2, value_3, values_updated}))
        else $error("output transaction changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 8'd0)
        else $error("output transaction without a matching input transaction");

    a_values_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !values_updated |-> value_0 == last0_reg && value_1 == last1_reg
            && value_2 == last2_reg && value_3 == last3_reg)
        else $error("held values changed without a refresh");

    a_refresh_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (values_updated == (gap_reg == GAP_LAST_C)))
        else $error("refresh not on every decimation boundary");

endmodule

bind adc_decimate_average_fault adm_checker #(.DECIMATION(DECIMATION)) u_adm_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for the four-channel ADC fault, decimate and moving-average block.
`timescale 1ns / 1ps

module testbench;
    import adm_pkg::*;

    localparam int    DECIM          = DECIMATION_DEF;
    localparam int    HIST_LEN       = HISTORY_LEN_DEF;
    localparam int    SETTLE_CYCLES  = LANE_LAT + 4;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    MAX_PRINTS     = 40;
    localparam int    SAMPLE_MAX     = (1 << SAMPLE_W) - 1;

    // Scaling constants of the divider and reference chains.
    localparam longint CH0_GAIN = 5990;
    localparam longint CH0_FULL = 65535;
    localparam longint CH0_NUM  = 33;
    localparam longint CH0_DEN  = 100;
    localparam longint REF_GAIN = 33000;
    localparam longint REF_FULL = 65520;
    localparam longint CH1_DIV  = 331;
    localparam longint CHN_DIV  = 11;

    typedef logic [MAX_CH-1:0][SAMPLE_W-1:0] tick_samples_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic                out_valid;
    logic                out_ready;
    logic [FAULT_W-1:0]  fault_0;
    logic [FAULT_W-1:0]  fault_1;
    logic [FAULT_W-1:0]  fault_2;
    logic [FAULT_W-1:0]  fault_3;
    logic [VALUE_W-1:0]  value_0;
    logic [3:0]          value_1;
    logic [VALUE_W-1:0]  value_2;
    logic [VALUE_W-1:0]  value_3;
    logic                values_updated;
    logic                cfg_we;
    logic [OFFSET_W-1:0] cfg_wdata;

    // Channel state as the block should hold it.
    logic [SUM_W-1:0]    chan_sum [MAX_CH];
    int                  tick_cnt;
    int                  avg_ring [MAX_CH][HIST_LEN];
    int                  ring_pos;
    int                  held_avg [MAX_CH];
    logic [OFFSET_W-1:0] cur_offset;

    result_t             pending_results [$];
    int                  error_count;
    int                  ticks_sent;
    int                  results_seen;
    int                  refreshes_seen;
    int                  idle_cycles;
    int                  hold_len;
    bit                  tx_idle_en;
    bit                  rx_idle_en;

    adc_decimate_average_fault dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_0       (sample_0),
        .sample_1       (sample_1),
        .sample_2       (sample_2),
        .sample_3       (sample_3),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .fault_0        (fault_0),
        .fault_1        (fault_1),
        .fault_2        (fault_2),
        .fault_3        (fault_3),
        .value_0        (value_0),
        .value_1        (value_1),
        .value_2        (value_2),
        .value_3        (value_3),
        .values_updated (values_updated),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic fault_t classify_sample(logic [SAMPLE_W-1:0] s);
        if (s > LIMIT_HIGH)
            return FAULT_ABOVE;
        if (s <= LIMIT_LOW)
            return FAULT_BELOW;
        return FAULT_NONE;
    endfunction

    function automatic longint scale_channel_sum(int ch, longint total);
        longint t;
        if (ch == 0)
        begin
            t = (total * CH0_GAIN) / CH0_FULL;
            return (t * CH0_NUM) / CH0_DEN;
        end
        t = (total * REF_GAIN) / REF_FULL;
        return (ch == 1) ? t / CH1_DIV : t / CHN_DIV;
    endfunction

    task automatic reset_channel_state();
        for (int ch = 0; ch < MAX_CH; ch++)
        begin
            chan_sum[ch] = '0;
            held_avg[ch] = 0;
            for (int j = 0; j < HIST_LEN; j++)
                avg_ring[ch][j] = 0;
        end
        tick_cnt   = 0;
        ring_pos   = 0;
        cur_offset = '0;
    endtask

    // Advances the channel state by one sampling tick and returns the result it should give.
    task automatic advance_tick(input tick_samples_t smp, output result_t res);
        longint scaled;
        longint ring_total;
        longint limit;
        res = '0;
        for (int ch = 0; ch < MAX_CH; ch++)
        begin
            res.fault[ch] = classify_sample(smp[ch]);
            chan_sum[ch]  = chan_sum[ch] + SUM_W'(smp[ch]);
        end
        tick_cnt++;
        if (tick_cnt >= DECIM)
        begin
            for (int ch = 0; ch < MAX_CH; ch++)
            begin
                scaled = scale_channel_sum(ch, longint'(chan_sum[ch]));
                avg_ring[ch][ring_pos] = int'(scaled & longint'(SAMPLE_MAX));
                ring_total = 0;
                for (int j = 0; j < HIST_LEN; j++)
                    ring_total += avg_ring[ch][j];
                ring_total = ring_total / AVG_DIVISOR;
                if (ch == 0)
                    ring_total += cur_offset;
                limit = (ch == 1) ? 15 : 511;
                held_avg[ch] = int'((ring_total > limit) ? limit : ring_total);
                chan_sum[ch] = '0;
            end
            tick_cnt = 0;
            ring_pos = (ring_pos + 1 >= HIST_LEN) ? 0 : ring_pos + 1;
            res.updated = 1'b1;
        end
        for (int ch = 0; ch < MAX_CH; ch++)
            res.value[ch] = VALUE_W'(held_avg[ch]);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sample source for the random windows: uniform, high band, low band, near a limit or rails.
    function automatic logic [SAMPLE_W-1:0] pick_sample(int mode);
        case (mode)
            1: return SAMPLE_W'($urandom_range(3400, SAMPLE_MAX));
            2: return SAMPLE_W'($urandom_range(0, 700));
            3: return ($urandom_range(0, 1) == 1) ?
                      SAMPLE_W'($urandom_range(LIMIT_HIGH - 6, LIMIT_HIGH + 6)) :
                      SAMPLE_W'($urandom_range(LIMIT_LOW - 6, LIMIT_LOW + 6));
            4: return ($urandom_range(0, 1) == 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
            default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] mismatch on result %0d: %s got %0d, expected %0d",
                     $realtime, results_seen, what, got, want);
    endtask

    // Offers one tick and returns at the edge where the transaction is accepted.
    task automatic send_tick(input tick_samples_t smp);
        int      gap;
        result_t want;
        gap = tx_idle_en ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_0 <= smp[0];
        sample_1 <= smp[1];
        sample_2 <= smp[2];
        sample_3 <= smp[3];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_tick(smp, want);
        pending_results.push_back(want);
        ticks_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_offset = val;
    endtask

    // Every result transaction is compared with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        result_t want;
        logic [MAX_CH-1:0][FAULT_W-1:0] got_fault;
        logic [MAX_CH-1:0][VALUE_W-1:0] got_value;
        if (rst_n && out_valid && out_ready)
        begin
            got_fault = {fault_3, fault_2, fault_1, fault_0};
            got_value = {value_3, value_2, {(VALUE_W - 4){1'b0}}, value_1, value_0};
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                for (int ch = 0; ch < MAX_CH; ch++)
                begin
                    if (got_fault[ch] !== want.fault[ch])
                        report_mismatch($sformatf("fault_%0d", ch), got_fault[ch],
                                        want.fault[ch]);
                    if (got_value[ch] !== want.value[ch])
                        report_mismatch($sformatf("value_%0d", ch), got_value[ch],
                                        want.value[ch]);
                end
                if (values_updated !== want.updated)
                    report_mismatch("values_updated", values_updated, want.updated);
                if (want.updated)
                    refreshes_seen++;
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Output side: a requested hold-off takes priority over the random stalls.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                out_ready <= 1'b0;
                hold_len--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_idle_en)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic test_fault_limits();
        int            edge_vals [12];
        tick_samples_t smp;
        edge_vals = '{0, 1, LIMIT_LOW, LIMIT_LOW + 1, LIMIT_LOW + 2, LIMIT_HIGH - 1,
                      LIMIT_HIGH, LIMIT_HIGH + 1, SAMPLE_MAX, 'h800, 'h555, 'haaa};
        for (int i = 0; i < 20; i++)
        begin
            for (int ch = 0; ch < MAX_CH; ch++)
                smp[ch] = SAMPLE_W'(edge_vals[(i + 3 * ch) % 12]);
            send_tick(smp);
        end
        wait_idle();
    endtask

    // Full-scale samples fill the whole ring with the offset at 255, so every average reaches its full-scale level.
    task automatic test_full_scale_average();
        tick_samples_t smp;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_offset(8'hff);
        for (int ch = 0; ch < MAX_CH; ch++)
            smp[ch] = SAMPLE_W'(SAMPLE_MAX);
        for (int i = 0; i < DECIM * HIST_LEN + 8; i++)
            send_tick(smp);
        wait_idle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_random_windows();
        int            mode [MAX_CH];
        tick_samples_t smp;
        write_offset(OFFSET_W'($urandom_range(1, 254)));
        for (int i = 0; i < 160; i++)
        begin
            if (i % DECIM == 0)
                for (int ch = 0; ch < MAX_CH; ch++)
                    mode[ch] = $urandom_range(0, 4);
            for (int ch = 0; ch < MAX_CH; ch++)
                smp[ch] = pick_sample(mode[ch]);
            send_tick(smp);
        end
        wait_idle();
    endtask

    // The result side holds off long enough for the result queue to fill and stop the input.
    task automatic test_output_hold_off();
        tick_samples_t smp;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_len   = 80;
        for (int i = 0; i < 48; i++)
        begin
            for (int ch = 0; ch < MAX_CH; ch++)
                smp[ch] = pick_sample(0);
            send_tick(smp);
        end
        wait_idle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_input_pause();
        tick_samples_t smp;
        write_offset(OFFSET_W'($urandom_range(1, 254)));
        for (int i = 0; i < 24; i++)
        begin
            for (int ch = 0; ch < MAX_CH; ch++)
                smp[ch] = pick_sample($urandom_range(0, 4));
            send_tick(smp);
        end
        drain_results();
        for (int i = 0; i < 24; i++)
        begin
            for (int ch = 0; ch < MAX_CH; ch++)
                smp[ch] = pick_sample($urandom_range(0, 4));
            send_tick(smp);
        end
        wait_idle();
        write_offset('0);
        for (int i = 0; i < 30; i++)
        begin
            for (int ch = 0; ch < MAX_CH; ch++)
                smp[ch] = pick_sample($urandom_range(0, 4));
            send_tick(smp);
        end
        wait_idle();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample_0       = '0;
        sample_1       = '0;
        sample_2       = '0;
        sample_3       = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        error_count    = 0;
        ticks_sent     = 0;
        results_seen   = 0;
        refreshes_seen = 0;
        idle_cycles    = 0;
        hold_len       = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        reset_channel_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fault_limits();
        test_full_scale_average();
        test_random_windows();
        test_output_hold_off();
        test_input_pause();

        $display("Sent %0d sample ticks and checked %0d results, %0d of them average refreshes,",
                 ticks_sent, results_seen, refreshes_seen);
        $display("across fault limits, full-scale averages, offsets 0, 255 and random, and stalls.");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
